// File: hdl/r4dtb_pkg.sv
// Shared types for the radix-4 twiddle butterfly pipeline.
package r4dtb_pkg;

    // Load enables for the three register stages of a twiddle multiplier.
    typedef struct packed {
        logic mul;
        logic acc;
        logic sat;
    } twmul_en_t;

endpackage

// File: hdl/radix4_dit_twiddle_butterfly.sv
// Top level: forward radix-4 DIT butterfly with twiddle multiplication.
//
// The slave channel (s_axis_*) takes one butterfly per item: four complex
// points and three complex twiddles packed in s_axis_tdata. The master
// channel (m_axis_*) returns the four outputs X0..X3 of that butterfly, each
// with components two bits wider than a sample, and no scaling.
//
// The datapath is a five-stage pipeline: partial products, product sums with
// the rounding constant, shift and saturation, the first adder rank and the
// second adder rank. One item is taken in every cycle while the master side
// accepts.
//
// Each stage carries a valid bit and loads whenever it is empty or the stage
// after it moves on, so empty slots close up while the receiver stalls and
// input is still taken until every stage holds an item. Nothing is dropped
// or repeated under back-pressure.
//
// The synchronous active-low reset clears the valid bits only, leaving the
// pipeline empty; data registers are not reset.
module radix4_dit_twiddle_butterfly #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int TWIDDLE_WIDTH = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // x0, x1, x2, x3, tw1, tw2, tw3 from the lowest bit up, zero padding to bytes
    input  logic [((8*SAMPLE_WIDTH+6*TWIDDLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // y0, y1, y2, y3 from the lowest bit up, zero padding to bytes
    output logic [((8*(SAMPLE_WIDTH+2)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int TW     = TWIDDLE_WIDTH;
    localparam int OW     = SW + 2;
    localparam int STAGES = 5;
    localparam int OUT_TD = ((8*OW + 7) / 8) * 8;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] load;

    r4dtb_pkg::twmul_en_t tw_en;

    logic signed [SW-1:0] ar_in, ai_in;
    logic signed [SW-1:0] ar_reg [3];
    logic signed [SW-1:0] ai_reg [3];
    logic signed [SW-1:0] br, bi, cr, ci, dr, di;

    logic signed [OW-1:0] sacr_reg, saci_reg, sbdr_reg, sbdi_reg;
    logic signed [OW-1:0] dacr_reg, daci_reg, dbdr_reg, dbdi_reg;
    logic signed [OW-1:0] sacr_next, saci_next, sbdr_next, sbdi_next;
    logic signed [OW-1:0] dacr_next, daci_next, dbdr_next, dbdi_next;

    logic signed [OW-1:0] y0r_reg, y0i_reg, y1r_reg, y1i_reg;
    logic signed [OW-1:0] y2r_reg, y2i_reg, y3r_reg, y3i_reg;
    logic signed [OW-1:0] y0r_next, y0i_next, y1r_next, y1i_next;
    logic signed [OW-1:0] y2r_next, y2i_next, y3r_next, y3i_next;

    // A stage loads when it is empty or its contents move on in this cycle.
    always_comb begin
        load[STAGES-1] = !valid_reg[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load[0]) begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = load[0];
    assign m_axis_tvalid = valid_reg[STAGES-1];

    assign tw_en.mul = load[0];
    assign tw_en.acc = load[1];
    assign tw_en.sat = load[2];

    r4dtb_twmul #(
        .SAMPLE_WIDTH (SW),
        .TWIDDLE_WIDTH(TW)
    ) u_twmul_b (
        .aclk(aclk),
        .en  (tw_en),
        .x   (s_axis_tdata[4*SW-1:2*SW]),
        .w   (s_axis_tdata[8*SW+2*TW-1:8*SW]),
        .re  (br),
        .im  (bi)
    );

    r4dtb_twmul #(
        .SAMPLE_WIDTH (SW),
        .TWIDDLE_WIDTH(TW)
    ) u_twmul_c (
        .aclk(aclk),
        .en  (tw_en),
        .x   (s_axis_tdata[6*SW-1:4*SW]),
        .w   (s_axis_tdata[8*SW+4*TW-1:8*SW+2*TW]),
        .re  (cr),
        .im  (ci)
    );

    r4dtb_twmul #(
        .SAMPLE_WIDTH (SW),
        .TWIDDLE_WIDTH(TW)
    ) u_twmul_d (
        .aclk(aclk),
        .en  (tw_en),
        .x   (s_axis_tdata[8*SW-1:6*SW]),
        .w   (s_axis_tdata[8*SW+6*TW-1:8*SW+4*TW]),
        .re  (dr),
        .im  (di)
    );

    // Point a needs no multiplication; it is delayed to match the multipliers.
    assign ar_in = s_axis_tdata[SW-1:0];
    assign ai_in = s_axis_tdata[2*SW-1:SW];

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            ar_reg[0] <= ar_in;
            ai_reg[0] <= ai_in;
        end
        if (load[1]) begin
            ar_reg[1] <= ar_reg[0];
            ai_reg[1] <= ai_reg[0];
        end
        if (load[2]) begin
            ar_reg[2] <= ar_reg[1];
            ai_reg[2] <= ai_reg[1];
        end
    end

    // First adder rank.
    assign sacr_next = OW'(ar_reg[2]) + OW'(cr);
    assign saci_next = OW'(ai_reg[2]) + OW'(ci);
    assign sbdr_next = OW'(br) + OW'(dr);
    assign sbdi_next = OW'(bi) + OW'(di);
    assign dacr_next = OW'(ar_reg[2]) - OW'(cr);
    assign daci_next = OW'(ai_reg[2]) - OW'(ci);
    assign dbdr_next = OW'(br) - OW'(dr);
    assign dbdi_next = OW'(bi) - OW'(di);

    // Second rank; multiplying (b-d) by -j or +j swaps its parts.
    assign y0r_next = sacr_reg + sbdr_reg;
    assign y0i_next = saci_reg + sbdi_reg;
    assign y1r_next = dacr_reg + dbdi_reg;
    assign y1i_next = daci_reg - dbdr_reg;
    assign y2r_next = sacr_reg - sbdr_reg;
    assign y2i_next = saci_reg - sbdi_reg;
    assign y3r_next = dacr_reg - dbdi_reg;
    assign y3i_next = daci_reg + dbdr_reg;

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            sacr_reg <= sacr_next;
            saci_reg <= saci_next;
            sbdr_reg <= sbdr_next;
            sbdi_reg <= sbdi_next;
            dacr_reg <= dacr_next;
            daci_reg <= daci_next;
            dbdr_reg <= dbdr_next;
            dbdi_reg <= dbdi_next;
        end
        if (load[4]) begin
            y0r_reg <= y0r_next;
            y0i_reg <= y0i_next;
            y1r_reg <= y1r_next;
            y1i_reg <= y1i_next;
            y2r_reg <= y2r_next;
            y2i_reg <= y2i_next;
            y3r_reg <= y3r_next;
            y3i_reg <= y3i_next;
        end
    end

    assign m_axis_tdata = OUT_TD'({y3i_reg, y3r_reg, y2i_reg, y2r_reg,
                                   y1i_reg, y1r_reg, y0i_reg, y0r_reg});

`ifndef SYNTHESIS
    // Input is refused only when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (&valid_reg))
        else $error("input refused while the pipeline has an empty stage");

    a_accept_fills_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[STAGES-1] && !m_axis_tready) |=>
            (valid_reg[STAGES-1] && $stable(y0r_reg) && $stable(y3i_reg)))
        else $error("stalled result changed in the output stage");

    a_no_bubble_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[3] && !valid_reg[4]) |=> valid_reg[4])
        else $error("item in the first adder rank did not move into an empty output stage");
`endif

endmodule

// File: hdl/r4dtb_twmul.sv
// Pipelined complex twiddle multiplier with round-to-nearest and saturation.
module r4dtb_twmul #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int TWIDDLE_WIDTH = 16
) (
    input  logic                           aclk,
    input  r4dtb_pkg::twmul_en_t           en,
    input  logic [2*SAMPLE_WIDTH-1:0]      x,
    input  logic [2*TWIDDLE_WIDTH-1:0]     w,
    output logic signed [SAMPLE_WIDTH-1:0] re,
    output logic signed [SAMPLE_WIDTH-1:0] im
);

    localparam int PW    = SAMPLE_WIDTH + TWIDDLE_WIDTH;
    localparam int SUM_W = PW + 2;

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (TWIDDLE_WIDTH - 2);
    localparam logic signed [SUM_W-1:0] MAXV =
        {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MINV =
        {{(SUM_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0]  xr, xi;
    logic signed [TWIDDLE_WIDTH-1:0] wr, wi;

    logic signed [PW-1:0]    prod_rr_reg, prod_ii_reg, prod_ri_reg, prod_ir_reg;
    logic signed [PW-1:0]    prod_rr_next, prod_ii_next, prod_ri_next, prod_ir_next;
    logic signed [SUM_W-1:0] sum_re_reg, sum_im_reg, sum_re_next, sum_im_next;
    logic signed [SUM_W-1:0] sh_re, sh_im;
    logic signed [SAMPLE_WIDTH-1:0] re_reg, im_reg, re_next, im_next;

    assign xr = x[SAMPLE_WIDTH-1:0];
    assign xi = x[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign wr = w[TWIDDLE_WIDTH-1:0];
    assign wi = w[2*TWIDDLE_WIDTH-1:TWIDDLE_WIDTH];

    // Stage 1: the four partial products, exact.
    assign prod_rr_next = PW'(xr) * PW'(wr);
    assign prod_ii_next = PW'(xi) * PW'(wi);
    assign prod_ri_next = PW'(xr) * PW'(wi);
    assign prod_ir_next = PW'(xi) * PW'(wr);

    // Stage 2: combine the products and add half an LSB of the result.
    assign sum_re_next = SUM_W'(prod_rr_reg) - SUM_W'(prod_ii_reg) + HALF;
    assign sum_im_next = SUM_W'(prod_ri_reg) + SUM_W'(prod_ir_reg) + HALF;

    // Stage 3: the arithmetic shift floors, then clamp to the sample range.
    assign sh_re = sum_re_reg >>> (TWIDDLE_WIDTH - 1);
    assign sh_im = sum_im_reg >>> (TWIDDLE_WIDTH - 1);

    always_comb begin
        if (sh_re > MAXV) begin
            re_next = MAXV[SAMPLE_WIDTH-1:0];
        end else if (sh_re < MINV) begin
            re_next = MINV[SAMPLE_WIDTH-1:0];
        end else begin
            re_next = sh_re[SAMPLE_WIDTH-1:0];
        end
        if (sh_im > MAXV) begin
            im_next = MAXV[SAMPLE_WIDTH-1:0];
        end else if (sh_im < MINV) begin
            im_next = MINV[SAMPLE_WIDTH-1:0];
        end else begin
            im_next = sh_im[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            prod_rr_reg <= prod_rr_next;
            prod_ii_reg <= prod_ii_next;
            prod_ri_reg <= prod_ri_next;
            prod_ir_reg <= prod_ir_next;
        end
        if (en.acc) begin
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
        end
        if (en.sat) begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

    assign re = re_reg;
    assign im = im_reg;

endmodule
